/* hw/rtl/owrs_pkg.sv */
// Shared definitions for the 1-Wire ROM search engine: command codes,
// the result bundle and the Dallas CRC8 byte update.
// No dependencies.
`timescale 1ns / 1ps

package owrs_pkg;

  // Command codes on the cmd field.
  localparam logic [1:0] CMD_FIRST = 2'd0;
  localparam logic [1:0] CMD_NEXT  = 2'd1;
  localparam logic [1:0] CMD_BIT   = 2'd2;

  // Bit position counter width (positions 1 .. 65).
  localparam int POS_W = 7;

  // Reflected polynomial for x^8 + x^5 + x^4 + 1.
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Highest position that still lies in the family byte, plus one.
  localparam logic [POS_W-1:0] FAMILY_LIMIT = 7'd9;

  // One result beat as it leaves the engine.
  typedef struct packed {
    logic        send_search_cmd;
    logic        write_dir;
    logic        direction;
    logic        done_res;
    logic        found;
    logic [63:0] rom_id;
    logic [3:0]  family_disc;
  } owrs_res_t;

  // Dallas CRC8 over one byte, least significant bit first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b   = data;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

endpackage

/* hw/rtl/one_wire_rom_search.sv */
// 1-Wire ROM search engine. Every command beat (begin first search, begin
// next search, or a bit pair read from the bus) produces exactly one result
// beat. Throughput is one beat per clock while the result register is not
// held by res_stall; a beat passes through the command register, then through
// the search step into the result register. The search state update for a
// beat is combinational, so consecutive beats never wait on each other. ID_BITS sets the id length.
//
// Top level: command register, search engine and result register.
// Depends on owrs_pkg and owrs_engine.
`timescale 1ns / 1ps

module one_wire_rom_search #(
  parameter int ID_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  cmd,
  input  logic        presence_ok,
  input  logic        id_bit,
  input  logic        complement_bit,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        send_search_cmd,
  output logic        write_dir,
  output logic        direction,
  output logic        done_res,
  output logic        found,
  output logic [63:0] rom_id,
  output logic [3:0]  family_disc
);
  import owrs_pkg::*;

  logic       in_valid;
  logic [1:0] in_cmd;
  logic       in_presence_ok;
  logic       in_id_bit;
  logic       in_complement_bit;
  logic       advance;
  logic       step;
  owrs_res_t  step_res;
  owrs_res_t  out_res;

  // The pipeline moves when the result register is empty or being taken.
  assign advance   = !res_valid || !res_stall;
  assign step      = in_valid && advance;
  assign cmd_stall = in_valid && !advance;

  // Command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!cmd_stall) begin
      in_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      in_cmd            <= cmd;
      in_presence_ok    <= presence_ok;
      in_id_bit         <= id_bit;
      in_complement_bit <= complement_bit;
    end
  end

  owrs_engine #(
    .ID_BITS(ID_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .cmd           (in_cmd),
    .presence_ok   (in_presence_ok),
    .id_bit        (in_id_bit),
    .complement_bit(in_complement_bit),
    .res           (step_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= step_res;
    end
  end

  assign send_search_cmd = out_res.send_search_cmd;
  assign write_dir       = out_res.write_dir;
  assign direction       = out_res.direction;
  assign done_res        = out_res.done_res;
  assign found           = out_res.found;
  assign rom_id          = out_res.rom_id;
  assign family_disc     = out_res.family_disc;

endmodule

/* hw/rtl/owrs_engine.sv */
// Search state and combinational step logic of the 1-Wire ROM search.
// Depends on owrs_pkg for command codes, the result struct and the CRC8.
`timescale 1ns / 1ps

module owrs_engine #(
  parameter int ID_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [1:0]            cmd,
  input  logic                  presence_ok,
  input  logic                  id_bit,
  input  logic                  complement_bit,
  output owrs_pkg::owrs_res_t   res
);
  import owrs_pkg::*;

  localparam logic [POS_W-1:0] END_POS = POS_W'(ID_BITS + 1);

  // Search state.
  logic [63:0]      rom_reg;
  logic [POS_W-1:0] last_disc;
  logic [3:0]       last_family_disc;
  logic             last_device;
  logic [POS_W-1:0] bit_pos;
  logic [POS_W-1:0] last_zero_pos;
  logic [7:0]       crc_reg;
  logic             active;

  logic [63:0]      rom_reg_next;
  logic [POS_W-1:0] last_disc_next;
  logic [3:0]       last_family_disc_next;
  logic             last_device_next;
  logic [POS_W-1:0] bit_pos_next;
  logic [POS_W-1:0] last_zero_pos_next;
  logic [7:0]       crc_reg_next;
  logic             active_next;

  // Step logic: one command beat updates the whole search state.
  always_comb begin
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_inc;
    logic [5:0]       sh;
    logic [2:0]       bidx;
    logic             dir;
    logic             found_v;

    rom_reg_next          = rom_reg;
    last_disc_next        = last_disc;
    last_family_disc_next = last_family_disc;
    last_device_next      = last_device;
    bit_pos_next          = bit_pos;
    last_zero_pos_next    = last_zero_pos;
    crc_reg_next          = crc_reg;
    active_next           = active;

    res.send_search_cmd = 1'b0;
    res.write_dir       = 1'b0;
    res.direction       = 1'b0;
    res.done_res        = 1'b0;
    res.found           = 1'b0;

    pos     = bit_pos;
    pos_inc = bit_pos + POS_W'(1);
    sh      = 6'(bit_pos - POS_W'(1));
    bidx    = 3'(((bit_pos - POS_W'(8)) >> 3));
    dir     = 1'b0;
    found_v = 1'b0;

    case (cmd)
      CMD_FIRST, CMD_NEXT: begin
        if (cmd == CMD_FIRST) begin
          last_disc_next        = '0;
          last_family_disc_next = '0;
          last_device_next      = 1'b0;
        end
        bit_pos_next       = POS_W'(1);
        last_zero_pos_next = '0;
        crc_reg_next       = '0;
        active_next        = 1'b0;
        if (last_device_next || !presence_ok) begin
          last_disc_next        = '0;
          last_family_disc_next = '0;
          last_device_next      = 1'b0;
          res.done_res          = 1'b1;
        end else begin
          active_next         = 1'b1;
          res.send_search_cmd = 1'b1;
        end
      end
      CMD_BIT: begin
        if (active) begin
          if (id_bit && complement_bit) begin
            // No device answered this bit.
            active_next           = 1'b0;
            last_disc_next        = '0;
            last_family_disc_next = '0;
            last_device_next      = 1'b0;
            res.done_res          = 1'b1;
          end else begin
            // Pick the direction: forced by the bus, or a discrepancy.
            if (id_bit != complement_bit) begin
              dir = id_bit;
            end else begin
              if (pos < last_disc) begin
                dir = rom_reg[sh];
              end else begin
                dir = (pos == last_disc);
              end
              if (!dir) begin
                last_zero_pos_next = pos;
                if (pos < FAMILY_LIMIT) begin
                  last_family_disc_next = pos[3:0];
                end
              end
            end
            rom_reg_next[sh] = dir;
            res.write_dir    = 1'b1;
            res.direction    = dir;

            // A completed byte goes through the CRC.
            if (pos[2:0] == 3'd0) begin
              crc_reg_next = crc8_byte(crc_reg, rom_reg_next[{bidx, 3'b000} +: 8]);
            end
            bit_pos_next = pos_inc;

            // End of the pass: check the id and move the markers.
            if (pos_inc >= END_POS) begin
              active_next  = 1'b0;
              res.done_res = 1'b1;
              if (crc_reg_next == 8'd0) begin
                last_disc_next = last_zero_pos_next;
                if (last_zero_pos_next == '0) begin
                  last_device_next = 1'b1;
                end
                found_v = 1'b1;
              end
              if (!found_v || rom_reg_next[7:0] == 8'd0) begin
                last_disc_next        = '0;
                last_family_disc_next = '0;
                last_device_next      = 1'b0;
                found_v               = 1'b0;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    res.found       = found_v;
    res.rom_id      = rom_reg_next;
    res.family_disc = last_family_disc_next;
  end

  // State registers advance once per accepted command beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      rom_reg          <= '0;
      last_disc        <= '0;
      last_family_disc <= '0;
      last_device      <= 1'b0;
      bit_pos          <= POS_W'(1);
      last_zero_pos    <= '0;
      crc_reg          <= '0;
      active           <= 1'b0;
    end else if (step) begin
      rom_reg          <= rom_reg_next;
      last_disc        <= last_disc_next;
      last_family_disc <= last_family_disc_next;
      last_device      <= last_device_next;
      bit_pos          <= bit_pos_next;
      last_zero_pos    <= last_zero_pos_next;
      crc_reg          <= crc_reg_next;
      active           <= active_next;
    end
  end

endmodule
